@@ sv/mmfn_pkg.sv @@
// Shared types and constants for the min-max feature normaliser.
// Used by mmfn_stats, mmfn_divider and minmax_feature_normalizer.
package mmfn_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = FRAC_W + 1;
    localparam int STEP_W   = $clog2(FRAC_W + 1);

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_TRAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNTRAINED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_RANGE = 2'd3;

    // Constants
    localparam logic [SCALED_W-1:0] ONE_Q16     = SCALED_W'(1 << FRAC_W);
    localparam logic [COUNT_W-1:0]  COUNT_RESET = 7'd64;

    // Statistics store control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } stats_ctrl_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ sv/mmfn_stats.sv @@
// Per-feature extremes store: max/min memory plus trained flags in flops.
// Depends on mmfn_pkg.
module mmfn_stats
    import mmfn_pkg::*;
#(
    parameter int MAX_FEATURES = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ADDR_W       = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  stats_ctrl_t             ctrl,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [SAMPLE_WIDTH-1:0] wr_max,
    input  logic [SAMPLE_WIDTH-1:0] wr_min,
    output logic [SAMPLE_WIDTH-1:0] rd_max,
    output logic [SAMPLE_WIDTH-1:0] rd_min,
    output logic                    rd_trained
);

    logic [2*SAMPLE_WIDTH-1:0] mem [MAX_FEATURES];
    logic [2*SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [MAX_FEATURES-1:0]   trained_reg;
    logic                      rd_trained_reg;

    // Extremes memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= {wr_max, wr_min};
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Trained flags act as valid bits: memory is not reset, so rd_trained marks an entry's extremes valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trained_reg    <= '0;
            rd_trained_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                trained_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                trained_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_trained_reg <= trained_reg[rd_addr];
            end
        end
    end

    assign rd_max     = rd_data_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign rd_min     = rd_data_reg[SAMPLE_WIDTH-1:0];
    assign rd_trained = rd_trained_reg;

endmodule

@@ sv/mmfn_divider.sv @@
// Radix-2 restoring divider: FRAC_W-bit quotient of (num << FRAC_W) / den, num < den.
// One quotient bit per cycle through a single subtractor. Depends on mmfn_pkg.
module mmfn_divider
    import mmfn_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     num,
    input  logic [DW-1:0]     den,
    output div_status_t       stat,
    output logic [FRAC_W-1:0] quotient
);

    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     rem_next;
    logic [DW-1:0]     den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DW:0]       shifted;
    logic [DW:0]       diff;
    logic              take;

    // Shift, trial subtract, keep or restore
    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        diff     = shifted - {1'b0, den_reg};
        take     = (shifted >= {1'b0, den_reg});
        rem_next = take ? diff[DW-1:0] : shifted[DW-1:0];
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(FRAC_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ sv/minmax_feature_normalizer.sv @@
// Min-max feature normaliser: clear, train and scale ops on per-feature extremes.
// Sequence: clear, unused op or bad index go from S_IDLE straight to S_FINISH; train and
// scale read the store in S_LOAD, where train writes back; a scale that ends without a
// divide (untrained, zero range or clamped) goes on to S_FINISH, else it runs S_DIV first.
// S_FINISH registers the result beat once the output is free. One item in flight at a time.
// Reset clears all trained flags and control state, sets the feature count to 64.
// Depends on mmfn_pkg, mmfn_stats and mmfn_divider.
module minmax_feature_normalizer
    import mmfn_pkg::*;
#(
    parameter int MAX_FEATURES = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [COUNT_W-1:0]             cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [OP_W-1:0]                opcode,
    input  logic [IDX_W-1:0]               feature_index,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [SCALED_W-1:0]            scaled_value,
    output logic [STATUS_W-1:0]            status
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOAD   = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [COUNT_W-1:0]             count_reg;
    logic [OP_W-1:0]                op_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SCALED_W-1:0]            res_scaled_reg;
    logic [SCALED_W-1:0]            res_scaled_next;
    logic [STATUS_W-1:0]            res_status_reg;
    logic [STATUS_W-1:0]            res_status_next;
    logic                           out_valid_reg;
    logic [SCALED_W-1:0]            scaled_reg;
    logic [STATUS_W-1:0]            status_reg;

    logic                           accept;
    logic                           in_range;
    logic                           is_stat_op;
    logic [IDX_W+ADDR_W-1:0]        idx_wide;
    logic [ADDR_W-1:0]              in_addr;
    stats_ctrl_t                    stats_ctrl;
    logic [SAMPLE_WIDTH-1:0]        rd_max;
    logic [SAMPLE_WIDTH-1:0]        rd_min;
    logic                           rd_trained;
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [SAMPLE_WIDTH-1:0] hi;
    logic signed [SAMPLE_WIDTH-1:0] new_max;
    logic signed [SAMPLE_WIDTH-1:0] new_min;
    logic signed [SAMPLE_WIDTH:0]   num_full;
    logic signed [SAMPLE_WIDTH:0]   den_full;
    logic                           div_start;
    div_status_t                    div_stat;
    logic [FRAC_W-1:0]              quotient;
    logic                           out_free;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign is_stat_op = opcode inside {OP_TRAIN, OP_SCALE};
    assign in_range   = ({1'b0, feature_index} < count_reg)
                        && (32'(feature_index) < 32'(MAX_FEATURES));
    assign idx_wide   = {{ADDR_W{1'b0}}, feature_index};
    assign in_addr    = idx_wide[ADDR_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;

    // Store control: read on accepting an in-range train or scale, write back on train, clear on clear op
    always_comb
    begin
        stats_ctrl.rd_en = accept && is_stat_op && in_range;
        stats_ctrl.wr_en = (state_reg == S_LOAD) && (op_reg == OP_TRAIN);
        stats_ctrl.clear = accept && (opcode == OP_CLEAR);
    end

    mmfn_stats #(
        .MAX_FEATURES (MAX_FEATURES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stats_ctrl),
        .rd_addr    (in_addr),
        .wr_addr    (addr_reg),
        .wr_max     (new_max),
        .wr_min     (new_min),
        .rd_max     (rd_max),
        .rd_min     (rd_min),
        .rd_trained (rd_trained)
    );

    // Effective extremes and the values derived from them
    always_comb
    begin
        lo       = rd_trained ? signed'(rd_min) : MOST_POS;
        hi       = rd_trained ? signed'(rd_max) : MOST_NEG;
        new_max  = (sample_reg > hi) ? sample_reg : hi;
        new_min  = (sample_reg < lo) ? sample_reg : lo;
        num_full = {sample_reg[SAMPLE_WIDTH-1], sample_reg} - {lo[SAMPLE_WIDTH-1], lo};
        den_full = {hi[SAMPLE_WIDTH-1], hi} - {lo[SAMPLE_WIDTH-1], lo};
    end

    mmfn_divider #(
        .DW (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_full[SAMPLE_WIDTH-1:0]),
        .den      (den_full[SAMPLE_WIDTH-1:0]),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        res_scaled_next = res_scaled_reg;
        res_status_next = res_status_reg;
        div_start       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_scaled_next = '0;
                    res_status_next = ST_OK;
                    if (is_stat_op && in_range)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        if (is_stat_op)
                        begin
                            res_status_next = ST_OUT_RANGE;
                        end
                        state_next = S_FINISH;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_FINISH;
                if (op_reg == OP_SCALE)
                begin
                    if (!rd_trained)
                    begin
                        res_status_next = ST_UNTRAINED;
                    end
                    else if (hi == lo)
                    begin
                        res_status_next = ST_ZERO_RANGE;
                    end
                    else if (sample_reg <= lo)
                    begin
                        res_scaled_next = '0;
                    end
                    else if (sample_reg >= hi)
                    begin
                        res_scaled_next = ONE_Q16;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_scaled_next = {1'b0, quotient};
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the item and the pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            addr_reg   <= in_addr;
            sample_reg <= sample_value;
        end
        res_scaled_reg <= res_scaled_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_FINISH) && out_free)
        begin
            scaled_reg <= res_scaled_reg;
            status_reg <= res_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scaled_value = scaled_reg;
    assign status       = status_reg;

    // A non-ok result never carries a scaled value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> scaled_value == '0)
    else $error("non-ok status with non-zero scaled value");

    // Scaled value never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scaled_value <= ONE_Q16)
    else $error("scaled value above one");

    // The divider only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV)
    else $error("divider busy outside divide state");

    // An accepted beat always leaves the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
    else $error("input ready straight after an accepted beat");

    // Store write never coincides with a read or a clear
    assert property (@(posedge clk) disable iff (!rst_n)
        stats_ctrl.wr_en |-> !stats_ctrl.rd_en && !stats_ctrl.clear)
    else $error("store write collides with read or clear");

endmodule
